### sv/block_cyclic_index_map_defines.svh
// assertion macros for the block cyclic index map
`ifndef BLOCK_CYCLIC_INDEX_MAP_DEFINES_SVH
`define BLOCK_CYCLIC_INDEX_MAP_DEFINES_SVH

`ifndef ASSERT_OFF
// combinational property checked at every clock edge outside reset
`define BCIM_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("block_cyclic_index_map: assertion failed");
// condition in one cycle implies a result in the next
`define BCIM_ASSERT_NEXT(lbl, clk, rst, cond, res) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (res)) \
      else $error("block_cyclic_index_map: assertion failed");
`else
`define BCIM_ASSERT(lbl, clk, rst, prop)
`define BCIM_ASSERT_NEXT(lbl, clk, rst, cond, res)
`endif

`endif

### sv/bcim_pkg.sv
`timescale 1ns / 1ps

package bcim_pkg;

   typedef enum logic [1:0] {
      OP_G2L = 2'd0,
      OP_L2G = 2'd1,
      OP_R2G = 2'd2
   } opcode_type;

   localparam int COORD_BITS_DEF = 20;
   localparam int GRID_BITS_DEF  = 8;

   localparam int BLOCK_W      = 13;
   localparam int BLOCK_MAX    = 4096;
   localparam int GRID_REG_W   = 9;
   localparam int MATRIX_REG_W = 21;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [2:0] REG_BLOCK_ROWS   = 3'd0;
   localparam logic [2:0] REG_BLOCK_COLS   = 3'd1;
   localparam logic [2:0] REG_GRID_ROWS    = 3'd2;
   localparam logic [2:0] REG_GRID_COLS    = 3'd3;
   localparam logic [2:0] REG_COLUMN_MAJOR = 3'd4;
   localparam logic [2:0] REG_MATRIX_ROWS  = 3'd5;
   localparam logic [2:0] REG_MATRIX_COLS  = 3'd6;

endpackage

### sv/bcim_div_cell.sv
`timescale 1ns / 1ps

// one restoring division step for two lanes, registered
module bcim_div_cell import bcim_pkg::*; #(
   parameter int NUM_W  = 20,
   parameter int DEN_W  = 13,
   parameter int SIDE_W = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        in_valid,
   input  logic [1:0][NUM_W-1:0]       in_num,
   input  logic [1:0][DEN_W-1:0]       in_den,
   input  logic [1:0][DEN_W-1:0]       in_rem,
   input  logic [1:0][NUM_W-1:0]       in_quo,
   input  logic [SIDE_W-1:0]           in_side,
   output logic                        out_valid,
   output logic [1:0][NUM_W-1:0]       out_num,
   output logic [1:0][DEN_W-1:0]       out_den,
   output logic [1:0][DEN_W-1:0]       out_rem,
   output logic [1:0][NUM_W-1:0]       out_quo,
   output logic [SIDE_W-1:0]           out_side
);

   logic                  valid_ff;
   logic [1:0][NUM_W-1:0] num_ff, num_in;
   logic [1:0][DEN_W-1:0] den_ff;
   logic [1:0][DEN_W-1:0] rem_ff, rem_in;
   logic [1:0][NUM_W-1:0] quo_ff, quo_in;
   logic [SIDE_W-1:0]     side_ff;

   logic [1:0][DEN_W:0]   shifted;
   logic [1:0][DEN_W:0]   diff;
   logic [1:0]            fits;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         shifted[l] = {in_rem[l], in_num[l][NUM_W-1]};
         diff[l]    = shifted[l] - {1'b0, in_den[l]};
         fits[l]    = shifted[l] >= {1'b0, in_den[l]};
         rem_in[l]  = fits[l] ? diff[l][DEN_W-1:0] : shifted[l][DEN_W-1:0];
         quo_in[l]  = {in_quo[l][NUM_W-2:0], fits[l]};
         num_in[l]  = {in_num[l][NUM_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         num_ff  <= num_in;
         den_ff  <= in_den;
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_num   = num_ff;
   assign out_den   = den_ff;
   assign out_rem   = rem_ff;
   assign out_quo   = quo_ff;
   assign out_side  = side_ff;

endmodule

### sv/bcim_div_chain.sv
`timescale 1ns / 1ps

`include "block_cyclic_index_map_defines.svh"

// row of division cells, one quotient bit per cell
module bcim_div_chain import bcim_pkg::*; #(
   parameter int NUM_W  = 20,
   parameter int DEN_W  = 13,
   parameter int SIDE_W = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  logic [1:0][NUM_W-1:0] in_num,
   input  logic [1:0][DEN_W-1:0] in_den,
   input  logic [SIDE_W-1:0]     in_side,
   output logic                  out_valid,
   output logic [1:0][NUM_W-1:0] out_quo,
   output logic [1:0][DEN_W-1:0] out_rem,
   output logic [SIDE_W-1:0]     out_side
);

   logic [NUM_W:0]                  vld_w;
   logic [NUM_W:0][1:0][NUM_W-1:0]  num_w;
   logic [NUM_W:0][1:0][NUM_W-1:0]  quo_w;
   logic [NUM_W:0][1:0][DEN_W-1:0]  den_w;
   logic [NUM_W:0][1:0][DEN_W-1:0]  rem_w;
   logic [NUM_W:0][SIDE_W-1:0]      side_w;

   assign vld_w[0]  = in_valid;
   assign num_w[0]  = in_num;
   assign den_w[0]  = in_den;
   assign rem_w[0]  = '0;
   assign quo_w[0]  = '0;
   assign side_w[0] = in_side;

   for (genvar i = 0; i < NUM_W; i++) begin : g_cell
      bcim_div_cell #(
         .NUM_W  (NUM_W),
         .DEN_W  (DEN_W),
         .SIDE_W (SIDE_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (vld_w[i]),
         .in_num    (num_w[i]),
         .in_den    (den_w[i]),
         .in_rem    (rem_w[i]),
         .in_quo    (quo_w[i]),
         .in_side   (side_w[i]),
         .out_valid (vld_w[i+1]),
         .out_num   (num_w[i+1]),
         .out_den   (den_w[i+1]),
         .out_rem   (rem_w[i+1]),
         .out_quo   (quo_w[i+1]),
         .out_side  (side_w[i+1])
      );
   end

   assign out_valid = vld_w[NUM_W];
   assign out_quo   = quo_w[NUM_W];
   assign out_rem   = rem_w[NUM_W];
   assign out_side  = side_w[NUM_W];

   // remainder never reaches the divisor
   `BCIM_ASSERT(a_rem_below_den, clock, reset, !out_valid || (out_rem[0] < den_w[NUM_W][0]))
   // an item entering lands in the first cell
   `BCIM_ASSERT_NEXT(a_first_cell_fill, clock, reset, in_valid && advance, vld_w[1])
   // a frozen chain keeps its last cell
   `BCIM_ASSERT_NEXT(a_hold_frozen, clock, reset, !advance, $stable(vld_w[NUM_W]))

endmodule

### sv/bcim_post.sv
`timescale 1ns / 1ps

// recombination: multiply back, bound checks, result register
module bcim_post import bcim_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int GRID_BITS  = GRID_BITS_DEF
) (
   clock, reset, advance, in_valid, in_op, in_pri, in_pci, in_rk,
   in_q1r, in_q1c, in_r1r, in_r1c, in_q2r, in_q2c, in_r2r, in_r2c,
   mb, nb, gr, gc, mr, mc, cm,
   out_valid, out_row, out_col, out_prow, out_pcol, out_rank, out_err
);
   localparam int CW   = COORD_BITS;
   localparam int GB   = GRID_BITS;
   localparam int GW   = GB + 1;
   localparam int RW   = 2 * GB;
   localparam int DW   = (CW > RW) ? CW : RW;
   localparam int BW   = BLOCK_W;
   localparam int DENW = (BW > GW) ? BW : GW;
   localparam int TW   = DW + GW + 1;
   localparam int UW   = TW + BW + 1;
   localparam int KW   = 2 * GW + 1;
   localparam int PW   = 2 * GW;

   input  logic            clock;
   input  logic            reset;
   input  logic            advance;
   input  logic            in_valid;
   input  logic [1:0]      in_op;
   input  logic [GB-1:0]   in_pri;
   input  logic [GB-1:0]   in_pci;
   input  logic [RW-1:0]   in_rk;
   input  logic [DW-1:0]   in_q1r;
   input  logic [DW-1:0]   in_q1c;
   input  logic [DENW-1:0] in_r1r;
   input  logic [DENW-1:0] in_r1c;
   input  logic [DW-1:0]   in_q2r;
   input  logic [DW-1:0]   in_q2c;
   input  logic [GW-1:0]   in_r2r;
   input  logic [GW-1:0]   in_r2c;
   input  logic [BW-1:0]   mb;
   input  logic [BW-1:0]   nb;
   input  logic [GW-1:0]   gr;
   input  logic [GW-1:0]   gc;
   input  logic [CW:0]     mr;
   input  logic [CW:0]     mc;
   input  logic            cm;
   output logic            out_valid;
   output logic [CW-1:0]   out_row;
   output logic [CW-1:0]   out_col;
   output logic [GB-1:0]   out_prow;
   output logic [GB-1:0]   out_pcol;
   output logic [RW-1:0]   out_rank;
   output logic            out_err;

   typedef struct packed {
      logic [1:0]      op;
      logic [GB-1:0]   pri;
      logic [GB-1:0]   pci;
      logic [RW-1:0]   rk;
      logic [DW-1:0]   q1r;
      logic [DENW-1:0] r1r;
      logic [DENW-1:0] r1c;
      logic [GW-1:0]   r2r;
      logic [GW-1:0]   r2c;
      logic [TW-1:0]   tr;
      logic [TW-1:0]   tc;
      logic [KW-1:0]   rank;
      logic [PW-1:0]   gprod;
   } s1_type;

   typedef struct packed {
      logic [1:0]      op;
      logic [GB-1:0]   pri;
      logic [GB-1:0]   pci;
      logic [DW-1:0]   q1r;
      logic [DENW-1:0] r1r;
      logic [GW-1:0]   r2r;
      logic [GW-1:0]   r2c;
      logic [KW-1:0]   rank;
      logic            rank_bad;
      logic [UW-1:0]   ur;
      logic [UW-1:0]   uc;
   } s2_type;

   typedef struct packed {
      logic [CW-1:0] row;
      logic [CW-1:0] col;
      logic [GB-1:0] prow;
      logic [GB-1:0] pcol;
      logic [RW-1:0] rank;
      logic          err;
   } res_type;

   logic    s1_valid_ff, s2_valid_ff, res_valid_ff;
   s1_type  s1_ff, s1_in;
   s2_type  s2_ff, s2_in;
   res_type res_ff, res_in;

   // first multiply: block index times grid size, owner rank, grid size
   always_comb begin
      s1_in.op    = in_op;
      s1_in.pri   = in_pri;
      s1_in.pci   = in_pci;
      s1_in.rk    = in_rk;
      s1_in.q1r   = in_q1r;
      s1_in.r1r   = in_r1r;
      s1_in.r1c   = in_r1c;
      s1_in.r2r   = in_r2r;
      s1_in.r2c   = in_r2c;
      if (in_op == OP_L2G) begin
         s1_in.tr = TW'(in_q1r) * TW'(gr) + TW'(in_pri);
         s1_in.tc = TW'(in_q1c) * TW'(gc) + TW'(in_pci);
      end else begin
         s1_in.tr = TW'(in_q2r);
         s1_in.tc = TW'(in_q2c);
      end
      if (cm) begin
         s1_in.rank = KW'(in_r2c) * KW'(gr) + KW'(in_r2r);
      end else begin
         s1_in.rank = KW'(in_r2r) * KW'(gc) + KW'(in_r2c);
      end
      s1_in.gprod = PW'(gr) * PW'(gc);
   end

   // second multiply: scale by block size, add offset in block
   always_comb begin
      s2_in.op       = s1_ff.op;
      s2_in.pri      = s1_ff.pri;
      s2_in.pci      = s1_ff.pci;
      s2_in.q1r      = s1_ff.q1r;
      s2_in.r1r      = s1_ff.r1r;
      s2_in.r2r      = s1_ff.r2r;
      s2_in.r2c      = s1_ff.r2c;
      s2_in.rank     = s1_ff.rank;
      s2_in.rank_bad = PW'(s1_ff.rk) >= s1_ff.gprod;
      s2_in.ur       = UW'(s1_ff.tr) * UW'(mb) + UW'(s1_ff.r1r);
      s2_in.uc       = UW'(s1_ff.tc) * UW'(nb) + UW'(s1_ff.r1c);
   end

   // result selection by opcode
   always_comb begin
      res_in = '0;
      case (s2_ff.op)
         OP_G2L: begin
            res_in.row  = s2_ff.ur[CW-1:0];
            res_in.col  = s2_ff.uc[CW-1:0];
            res_in.prow = s2_ff.r2r[GB-1:0];
            res_in.pcol = s2_ff.r2c[GB-1:0];
            res_in.rank = s2_ff.rank[RW-1:0];
         end
         OP_L2G: begin
            res_in.prow = s2_ff.pri;
            res_in.pcol = s2_ff.pci;
            if ((s2_ff.ur >= UW'(mr)) || (s2_ff.uc >= UW'(mc))) begin
               res_in.err = 1'b1;
            end else begin
               res_in.row = s2_ff.ur[CW-1:0];
               res_in.col = s2_ff.uc[CW-1:0];
            end
         end
         OP_R2G: begin
            if (s2_ff.rank_bad) begin
               res_in.err = 1'b1;
            end else if (cm) begin
               res_in.prow = s2_ff.r1r[GB-1:0];
               res_in.pcol = s2_ff.q1r[GB-1:0];
            end else begin
               res_in.prow = s2_ff.q1r[GB-1:0];
               res_in.pcol = s2_ff.r1r[GB-1:0];
            end
         end
         default: begin
            res_in.err = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         res_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= in_valid;
         s2_valid_ff  <= s1_valid_ff;
         res_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff  <= s1_in;
         s2_ff  <= s2_in;
         res_ff <= res_in;
      end
   end

   assign out_valid = res_valid_ff;
   assign out_row   = res_ff.row;
   assign out_col   = res_ff.col;
   assign out_prow  = res_ff.prow;
   assign out_pcol  = res_ff.pcol;
   assign out_rank  = res_ff.rank;
   assign out_err   = res_ff.err;

endmodule

### sv/block_cyclic_index_map.sv
`timescale 1ns / 1ps

// 2d block-cyclic index translator. one item per clock is accepted and one
// result item per clock is delivered while no result is held. the pipeline
// is built from two chains of restoring-division cells, one quotient bit
// per cell: the first divides the coordinates by the block size (or the
// rank by the grid size), the second divides the block indexes by the grid
// size. three multiply and check stages follow. a stalled result freezes
// the whole pipeline, so req_stall follows rsp_stall while a result waits.
// the user must write registers through the csr port only while the block
// is idle; the block itself does not enforce this. out-of-range register
// values are clamped to their legal bounds before use.
`include "block_cyclic_index_map_defines.svh"

module block_cyclic_index_map import bcim_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int GRID_BITS  = GRID_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_opcode,
   input  logic [COORD_BITS-1:0]     req_row_index,
   input  logic [COORD_BITS-1:0]     req_col_index,
   input  logic [GRID_BITS-1:0]      req_proc_row_in,
   input  logic [GRID_BITS-1:0]      req_proc_col_in,
   input  logic [2*GRID_BITS-1:0]    req_rank_in,
   // response channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [COORD_BITS-1:0]     rsp_out_row,
   output logic [COORD_BITS-1:0]     rsp_out_col,
   output logic [GRID_BITS-1:0]      rsp_proc_row_out,
   output logic [GRID_BITS-1:0]      rsp_proc_col_out,
   output logic [2*GRID_BITS-1:0]    rsp_owner_rank,
   output logic                      rsp_range_error,
   // csr port
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [CSR_DATA_W-1:0]     csr_pwdata,
   output logic [CSR_DATA_W-1:0]     csr_prdata,
   output logic                      csr_pready
);

   localparam int CW    = COORD_BITS;
   localparam int GB    = GRID_BITS;
   localparam int GW    = GB + 1;
   localparam int RW    = 2 * GB;
   localparam int DW    = (CW > RW) ? CW : RW;
   localparam int BW    = BLOCK_W;
   localparam int DENW  = (BW > GW) ? BW : GW;
   localparam int SIDE1 = 2 + 2 * GB + RW;
   localparam int SIDE2 = SIDE1 + 2 * DW + 2 * DENW;

   // clamp a register value into 1..hi
   function automatic logic [63:0] clamp_reg(input logic [63:0] v, input logic [63:0] hi);
      logic [63:0] r;
      if (v == 64'd0) begin
         r = 64'd1;
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // ---------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------
   logic [BW-1:0]           block_rows_ff, block_rows_in;
   logic [BW-1:0]           block_cols_ff, block_cols_in;
   logic [GRID_REG_W-1:0]   grid_rows_ff, grid_rows_in;
   logic [GRID_REG_W-1:0]   grid_cols_ff, grid_cols_in;
   logic                    column_major_ff, column_major_in;
   logic [MATRIX_REG_W-1:0] matrix_rows_ff, matrix_rows_in;
   logic [MATRIX_REG_W-1:0] matrix_cols_ff, matrix_cols_in;
   logic [2:0]              csr_index;
   logic                    csr_write;

   assign csr_index  = csr_paddr[4:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      block_rows_in   = block_rows_ff;
      block_cols_in   = block_cols_ff;
      grid_rows_in    = grid_rows_ff;
      grid_cols_in    = grid_cols_ff;
      column_major_in = column_major_ff;
      matrix_rows_in  = matrix_rows_ff;
      matrix_cols_in  = matrix_cols_ff;
      if (csr_write) begin
         case (csr_index)
            REG_BLOCK_ROWS:   block_rows_in   = csr_pwdata[BW-1:0];
            REG_BLOCK_COLS:   block_cols_in   = csr_pwdata[BW-1:0];
            REG_GRID_ROWS:    grid_rows_in    = csr_pwdata[GRID_REG_W-1:0];
            REG_GRID_COLS:    grid_cols_in    = csr_pwdata[GRID_REG_W-1:0];
            REG_COLUMN_MAJOR: column_major_in = csr_pwdata[0];
            REG_MATRIX_ROWS:  matrix_rows_in  = csr_pwdata[MATRIX_REG_W-1:0];
            REG_MATRIX_COLS:  matrix_cols_in  = csr_pwdata[MATRIX_REG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_rows_ff   <= BW'(1);
         block_cols_ff   <= BW'(1);
         grid_rows_ff    <= GRID_REG_W'(1);
         grid_cols_ff    <= GRID_REG_W'(1);
         column_major_ff <= 1'b1;
         matrix_rows_ff  <= MATRIX_REG_W'(1);
         matrix_cols_ff  <= MATRIX_REG_W'(1);
      end else begin
         block_rows_ff   <= block_rows_in;
         block_cols_ff   <= block_cols_in;
         grid_rows_ff    <= grid_rows_in;
         grid_cols_ff    <= grid_cols_in;
         column_major_ff <= column_major_in;
         matrix_rows_ff  <= matrix_rows_in;
         matrix_cols_ff  <= matrix_cols_in;
      end
   end

   // register readback
   always_comb begin
      case (csr_index)
         REG_BLOCK_ROWS:   csr_prdata = CSR_DATA_W'(block_rows_ff);
         REG_BLOCK_COLS:   csr_prdata = CSR_DATA_W'(block_cols_ff);
         REG_GRID_ROWS:    csr_prdata = CSR_DATA_W'(grid_rows_ff);
         REG_GRID_COLS:    csr_prdata = CSR_DATA_W'(grid_cols_ff);
         REG_COLUMN_MAJOR: csr_prdata = CSR_DATA_W'(column_major_ff);
         REG_MATRIX_ROWS:  csr_prdata = CSR_DATA_W'(matrix_rows_ff);
         REG_MATRIX_COLS:  csr_prdata = CSR_DATA_W'(matrix_cols_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // clamped working values; the user must change registers only while idle, which the block does not enforce
   logic [BW-1:0] mb, nb;
   logic [GW-1:0] gr, gc;
   logic [CW:0]   mr, mc;

   assign mb = BW'(clamp_reg(64'(block_rows_ff), 64'(BLOCK_MAX)));
   assign nb = BW'(clamp_reg(64'(block_cols_ff), 64'(BLOCK_MAX)));
   assign gr = GW'(clamp_reg(64'(grid_rows_ff), 64'd1 << GB));
   assign gc = GW'(clamp_reg(64'(grid_cols_ff), 64'd1 << GB));
   assign mr = (CW + 1)'(clamp_reg(64'(matrix_rows_ff), 64'd1 << CW));
   assign mc = (CW + 1)'(clamp_reg(64'(matrix_cols_ff), 64'd1 << CW));

   // ---------------------------------------------------------------
   // pipeline control: everything moves unless a result is held
   // ---------------------------------------------------------------
   logic advance;

   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   // ---------------------------------------------------------------
   // first chain: coordinate / block size, or rank / grid size
   // ---------------------------------------------------------------
   logic [1:0][DW-1:0]   c1_num;
   logic [1:0][DENW-1:0] c1_den;
   logic [SIDE1-1:0]     c1_side_in, c1_side_out;
   logic                 c1_valid;
   logic [1:0][DW-1:0]   c1_quo;
   logic [1:0][DENW-1:0] c1_rem;
   logic [1:0]           c1_op;
   logic [GB-1:0]        c1_pri, c1_pci;
   logic [RW-1:0]        c1_rk;

   always_comb begin
      if (req_opcode == OP_R2G) begin
         // rank split uses the row lane
         c1_num[0] = DW'(req_rank_in);
         c1_den[0] = column_major_ff ? DENW'(gr) : DENW'(gc);
      end else begin
         c1_num[0] = DW'(req_row_index);
         c1_den[0] = DENW'(mb);
      end
      c1_num[1] = DW'(req_col_index);
      c1_den[1] = DENW'(nb);
   end

   assign c1_side_in = {req_opcode, req_proc_row_in, req_proc_col_in, req_rank_in};

   bcim_div_chain #(
      .NUM_W  (DW),
      .DEN_W  (DENW),
      .SIDE_W (SIDE1)
   ) u_chain_block (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_num    (c1_num),
      .in_den    (c1_den),
      .in_side   (c1_side_in),
      .out_valid (c1_valid),
      .out_quo   (c1_quo),
      .out_rem   (c1_rem),
      .out_side  (c1_side_out)
   );

   assign {c1_op, c1_pri, c1_pci, c1_rk} = c1_side_out;

   // ---------------------------------------------------------------
   // second chain: block index / grid size gives owner and local block
   // ---------------------------------------------------------------
   logic [1:0][GW-1:0]   c2_den;
   logic [SIDE2-1:0]     c2_side_in, c2_side_out;
   logic                 c2_valid;
   logic [1:0][DW-1:0]   c2_quo;
   logic [1:0][GW-1:0]   c2_rem;
   logic [1:0]           p_op;
   logic [GB-1:0]        p_pri, p_pci;
   logic [RW-1:0]        p_rk;
   logic [DW-1:0]        p_q1r, p_q1c;
   logic [DENW-1:0]      p_r1r, p_r1c;

   assign c2_den[0]  = gr;
   assign c2_den[1]  = gc;
   assign c2_side_in = {c1_op, c1_pri, c1_pci, c1_rk,
                        c1_quo[0], c1_quo[1], c1_rem[0], c1_rem[1]};

   bcim_div_chain #(
      .NUM_W  (DW),
      .DEN_W  (GW),
      .SIDE_W (SIDE2)
   ) u_chain_grid (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (c1_valid),
      .in_num    (c1_quo),
      .in_den    (c2_den),
      .in_side   (c2_side_in),
      .out_valid (c2_valid),
      .out_quo   (c2_quo),
      .out_rem   (c2_rem),
      .out_side  (c2_side_out)
   );

   assign {p_op, p_pri, p_pci, p_rk, p_q1r, p_q1c, p_r1r, p_r1c} = c2_side_out;

   // ---------------------------------------------------------------
   // recombination and result register
   // ---------------------------------------------------------------
   bcim_post #(
      .COORD_BITS (COORD_BITS),
      .GRID_BITS  (GRID_BITS)
   ) u_post (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (c2_valid),
      .in_op     (p_op),
      .in_pri    (p_pri),
      .in_pci    (p_pci),
      .in_rk     (p_rk),
      .in_q1r    (p_q1r),
      .in_q1c    (p_q1c),
      .in_r1r    (p_r1r),
      .in_r1c    (p_r1c),
      .in_q2r    (c2_quo[0]),
      .in_q2c    (c2_quo[1]),
      .in_r2r    (c2_rem[0]),
      .in_r2c    (c2_rem[1]),
      .mb        (mb),
      .nb        (nb),
      .gr        (gr),
      .gc        (gc),
      .mr        (mr),
      .mc        (mc),
      .cm        (column_major_ff),
      .out_valid (rsp_valid),
      .out_row   (rsp_out_row),
      .out_col   (rsp_out_col),
      .out_prow  (rsp_proc_row_out),
      .out_pcol  (rsp_proc_col_out),
      .out_rank  (rsp_owner_rank),
      .out_err   (rsp_range_error)
   );

   // flagged results carry no coordinate
   `BCIM_ASSERT(a_err_zero_coord, clock, reset, !(rsp_valid && rsp_range_error) || ((rsp_out_row == '0) && (rsp_out_col == '0)))
   // only a global to local result carries a rank, and it never flags
   `BCIM_ASSERT(a_rank_no_err, clock, reset, !(rsp_valid && (rsp_owner_rank != '0)) || !rsp_range_error)
   // a held result stalls the request side in the same cycle
   `BCIM_ASSERT(a_hold_stalls_req, clock, reset, !(rsp_valid && rsp_stall) || req_stall)

endmodule
